FILE: src/lppd_pkg.sv
`default_nettype none
package lppd_pkg;

	localparam int BUFFER_BYTES = 32;
	// Three bytes of the buffer are reserved by the frame format.
	localparam int STORE_DEPTH  = BUFFER_BYTES - 3;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int LEN_W        = 5;
	localparam int BYTE_W       = 8;
	localparam int IDX_W        = 2;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(STORE_DEPTH);

	localparam logic [IDX_W-1:0] REG_START_MARKER = 2'd0;
	localparam logic [IDX_W-1:0] REG_ACK_MARKER   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hA0;
	localparam logic [BYTE_W-1:0] ACK_MARKER_RST   = 8'hB0;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic take_seq;
		logic take_len;
		logic take_data;
		logic rd_start;
		logic rd_next;
		logic load_pay;
		logic load_ack0;
		logic load_ack1;
	} lppd_cmd_t;

	typedef struct packed {
		logic start_hit;
		logic len_too_big;
		logic len_zero;
		logic data_last;
		logic drain_last;
		logic busy;
		logic out_free;
	} lppd_sts_t;

endpackage
`default_nettype wire

FILE: src/length_prefixed_packet_deframer_top.sv
// The first result of a frame is loaded through the ST_RD and ST_LD states after its last byte
// is taken, or from ST_ACK0 when only the acknowledge is sent (zero length or a busy bus).
// Throughput: one link byte per cycle while a frame is received; a completing frame of n
// payload bytes then takes one store read, n payload items and two acknowledge items, or
// the two acknowledge items alone, and no byte is taken meanwhile.
// Reset: registers return to their defaults, the block hunts and the output is empty.
`default_nettype none
module length_prefixed_packet_deframer_top
	import lppd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [BYTE_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              bus_busy,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_kind,
	output logic      [BYTE_W-1:0] out_byte,
	output logic      [LEN_W-1:0]  packet_length,
	output logic                   out_last
);

	lppd_cmd_t cmd;
	lppd_sts_t sts;

	assign cfg_ready = 1'b1;

	lppd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lppd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.bus_busy     (bus_busy),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.packet_length(packet_length),
		.out_last     (out_last)
	);

	// No link byte is taken while the store is being drained.
	a_no_input_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_start || cmd.rd_next || cmd.load_pay) |-> !in_ready)
		else $error("input taken while draining the store");

	// The sequence byte of the acknowledge is the last result and is shown next cycle.
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_ack1 |=> (out_valid && out_last && out_kind == KIND_ACK))
		else $error("acknowledge tail not presented as last item");

	// A payload item only comes from a frame with a nonzero length.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == KIND_PAYLOAD) |-> (packet_length != '0 && !out_last))
		else $error("payload item with zero length or marked last");

	// An item is loaded only when the output register is free.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !(cmd.load_pay || cmd.load_ack0 || cmd.load_ack1))
		else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

FILE: src/lppd_ram.sv
`default_nettype none
module lppd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/lppd_ctrl.sv
`default_nettype none
module lppd_ctrl
	import lppd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire lppd_sts_t sts,
	output lppd_cmd_t      cmd
);

	localparam logic [2:0] ST_HUNT = 3'd0;
	localparam logic [2:0] ST_SEQ  = 3'd1;
	localparam logic [2:0] ST_LEN  = 3'd2;
	localparam logic [2:0] ST_DATA = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_LD   = 3'd5;
	localparam logic [2:0] ST_ACK0 = 3'd6;
	localparam logic [2:0] ST_ACK1 = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_HUNT: begin
				in_ready = 1'b1;
				if (in_valid && sts.start_hit) begin
					state_nxt = ST_SEQ;
				end
			end
			ST_SEQ: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_seq = 1'b1;
					state_nxt    = ST_LEN;
				end
			end
			ST_LEN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.len_too_big) begin
						state_nxt = ST_HUNT;
					end else begin
						cmd.take_len = 1'b1;
						state_nxt    = sts.len_zero ? ST_ACK0 : ST_DATA;
					end
				end
			end
			ST_DATA: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_data = 1'b1;
					if (sts.data_last) begin
						// A busy bus drops the payload but still gets the acknowledge.
						state_nxt = sts.busy ? ST_ACK0 : ST_RD;
					end
				end
			end
			ST_RD: begin
				cmd.rd_start = 1'b1;
				state_nxt    = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.load_pay = 1'b1;
					if (sts.drain_last) begin
						state_nxt = ST_ACK0;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_ACK0: begin
				if (sts.out_free) begin
					cmd.load_ack0 = 1'b1;
					state_nxt     = ST_ACK1;
				end
			end
			ST_ACK1: begin
				if (sts.out_free) begin
					cmd.load_ack1 = 1'b1;
					state_nxt     = ST_HUNT;
				end
			end
			default: begin
				state_nxt = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: src/lppd_dp.sv
`default_nettype none
module lppd_dp
	import lppd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [BYTE_W-1:0] cfg_data,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              bus_busy,
	input  wire lppd_cmd_t         cmd,
	output lppd_sts_t              sts,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   out_kind,
	output logic      [BYTE_W-1:0] out_byte,
	output logic      [LEN_W-1:0]  packet_length,
	output logic                   out_last
);

	logic [BYTE_W-1:0] start_marker_q;
	logic [BYTE_W-1:0] ack_marker_q;
	logic [LEN_W-1:0]  max_payload_q;
	logic [BYTE_W-1:0] seq_q;
	logic [LEN_W-1:0]  frame_len_q;
	logic [LEN_W-1:0]  taken_q;
	logic [ADDR_W-1:0] rd_cnt_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  limit;
	logic [LEN_W:0]    taken_inc;
	logic [ADDR_W:0]   rd_inc;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// A limit above the store size acts as the store size.
	assign limit     = (max_payload_q > MAX_LEN) ? MAX_LEN : max_payload_q;
	assign taken_inc = {1'b0, taken_q} + (LEN_W+1)'(1);
	assign rd_inc    = {1'b0, rd_cnt_q} + (ADDR_W+1)'(1);

	assign sts.start_hit   = (rx_byte == start_marker_q);
	assign sts.len_too_big = (rx_byte > {{(BYTE_W-LEN_W){1'b0}}, limit});
	assign sts.len_zero    = (rx_byte == '0);
	assign sts.data_last   = (taken_inc == {1'b0, frame_len_q});
	assign sts.drain_last  = ((LEN_W+1)'(rd_inc) == {1'b0, frame_len_q});
	assign sts.busy        = bus_busy;
	assign sts.out_free    = !out_valid_q || out_ready;

	// Reads run one address ahead, so the next byte is ready when the output frees up.
	assign ram_re    = cmd.rd_start || cmd.rd_next;
	assign ram_raddr = cmd.rd_start ? '0 : rd_inc[ADDR_W-1:0];

	lppd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.take_data),
		.waddr(taken_q[ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			ack_marker_q   <= ACK_MARKER_RST;
			max_payload_q  <= MAX_LEN;
			seq_q          <= '0;
			frame_len_q    <= '0;
			taken_q        <= '0;
			rd_cnt_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_START_MARKER: start_marker_q <= cfg_data;
					REG_ACK_MARKER:   ack_marker_q   <= cfg_data;
					REG_MAX_PAYLOAD:  max_payload_q  <= cfg_data[LEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.take_seq) begin
				seq_q <= rx_byte;
			end
			if (cmd.take_len) begin
				frame_len_q <= rx_byte[LEN_W-1:0];
				taken_q     <= '0;
			end else if (cmd.take_data) begin
				taken_q <= taken_inc[LEN_W-1:0];
			end
			if (cmd.rd_start) begin
				rd_cnt_q <= '0;
			end else if (cmd.rd_next) begin
				rd_cnt_q <= rd_inc[ADDR_W-1:0];
			end
			if (cmd.load_pay || cmd.load_ack0 || cmd.load_ack1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pay || cmd.load_ack0 || cmd.load_ack1) begin
			packet_length <= frame_len_q;
			out_last      <= cmd.load_ack1;
			out_kind      <= cmd.load_pay ? KIND_PAYLOAD : KIND_ACK;
			priority if (cmd.load_pay) begin
				out_byte <= ram_rdata;
			end else if (cmd.load_ack0) begin
				out_byte <= ack_marker_q;
			end else begin
				out_byte <= seq_q;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
